>>> hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Shared widths, request and status codes, and the structs that pass
// between the list cells, the result reduction and the top level.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int MAX_ENTRIES   = 64;
   localparam int TAG_BITS      = 16;
   localparam int QTY_BITS      = 32;
   localparam int REQ_TYPE_BITS = 3;
   localparam int POS_BITS      = 8;
   localparam int STATUS_BITS   = 2;
   localparam int IDX_BITS      = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS      = $clog2(MAX_ENTRIES + 1);

   localparam int GROUP_SIZE    = 8;
   localparam int NUM_GROUPS    = MAX_ENTRIES / GROUP_SIZE;
   localparam int GRP_BITS      = $clog2(GROUP_SIZE);
   localparam int GIDX_BITS     = IDX_BITS - GRP_BITS;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_INSERT = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_REMOVE = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_READ   = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_WRITE  = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_FIND   = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_MISS  = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_WRITE  = 2'd3;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [QTY_BITS-1:0] qty;
   } entry_type;

   typedef struct packed {
      logic                exec;
      logic [1:0]          op;
      logic [IDX_BITS-1:0] pos;
      logic [TAG_BITS-1:0] tag;
      logic [QTY_BITS-1:0] qty;
      logic                read_en;
      logic                find_en;
      logic [CNT_BITS-1:0] count;
   } cell_cmd_type;

   typedef struct packed {
      logic                find_hit;
      logic [TAG_BITS-1:0] rd_tag;
      logic [QTY_BITS-1:0] rd_qty;
   } cell_hit_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] index;
      logic [TAG_BITS-1:0] tag;
      logic [QTY_BITS-1:0] qty;
   } reduce_result_type;

endpackage

>>> hw/rtl/pls_req_if.sv
// ----------------------------------------------------------------------------
// Positional list store request channel
// Valid/ready channel that carries one list request.
// ----------------------------------------------------------------------------
interface pls_req_if import pls_pkg::*; ();

   logic                            valid;
   logic                            ready;
   logic        [REQ_TYPE_BITS-1:0] req_type;
   logic signed [POS_BITS-1:0]      position;
   logic        [TAG_BITS-1:0]      item_tag;
   logic signed [QTY_BITS-1:0]      quantity;

   modport source (output valid, output req_type, output position, output item_tag,
                   output quantity, input ready);
   modport sink   (input valid, input req_type, input position, input item_tag,
                   input quantity, output ready);

endinterface

>>> hw/rtl/pls_rsp_if.sv
// ----------------------------------------------------------------------------
// Positional list store response channel
// Valid/ready channel that carries the result of one list request.
// ----------------------------------------------------------------------------
interface pls_rsp_if import pls_pkg::*; ();

   logic                          valid;
   logic                          ready;
   logic        [STATUS_BITS-1:0] status;
   logic        [TAG_BITS-1:0]    item_out;
   logic signed [QTY_BITS-1:0]    quantity_out;
   logic        [IDX_BITS-1:0]    found_index;
   logic        [CNT_BITS-1:0]    entry_count;

   modport source (output valid, output status, output item_out, output quantity_out,
                   output found_index, output entry_count, input ready);
   modport sink   (input valid, input status, input item_out, input quantity_out,
                   input found_index, input entry_count, output ready);

endinterface

>>> hw/rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// Positional list store cell
// Holds one list entry, shifts with its neighbors on insert and remove,
// and flags a position or tag match for read and find.
// ----------------------------------------------------------------------------
module pls_cell import pls_pkg::*; (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [IDX_BITS-1:0] cell_index,
   input  entry_type           left_entry,
   input  entry_type           right_entry,
   output entry_type           entry,
   output cell_hit_type        hit
);

   entry_type    entry_ff;
   entry_type    entry_in;
   cell_hit_type hit_ff;
   cell_hit_type hit_in;
   entry_type    new_entry;
   logic         at_pos;

   assign new_entry = '{tag: cmd.tag, qty: cmd.qty};
   assign at_pos    = (cell_index == cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_index > cmd.pos) begin
               entry_in = left_entry;
            end else if (at_pos) begin
               entry_in = new_entry;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= cmd.pos) begin
               entry_in = right_entry;
            end
         end
         CELL_WRITE: begin
            if (at_pos) begin
               entry_in = new_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_comb begin
      hit_in.find_hit = cmd.find_en && ({1'b0, cell_index} < cmd.count) &&
                        (entry_ff.tag == cmd.tag);
      hit_in.rd_tag   = (cmd.read_en && at_pos) ? entry_ff.tag : '0;
      hit_in.rd_qty   = (cmd.read_en && at_pos) ? entry_ff.qty : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

>>> hw/rtl/pls_reduce.sv
// ----------------------------------------------------------------------------
// Positional list store result reduction
// Two-level tree that merges the cell match flags into the first matching
// index and the read entry; the group level is registered.
// ----------------------------------------------------------------------------
module pls_reduce import pls_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  cell_hit_type      hits [MAX_ENTRIES],
   output reduce_result_type result
);

   logic                 grp_any_ff   [NUM_GROUPS];
   logic [GRP_BITS-1:0]  grp_first_ff [NUM_GROUPS];
   logic [TAG_BITS-1:0]  grp_tag_ff   [NUM_GROUPS];
   logic [QTY_BITS-1:0]  grp_qty_ff   [NUM_GROUPS];
   logic                 grp_any_in   [NUM_GROUPS];
   logic [GRP_BITS-1:0]  grp_first_in [NUM_GROUPS];
   logic [TAG_BITS-1:0]  grp_tag_in   [NUM_GROUPS];
   logic [QTY_BITS-1:0]  grp_qty_in   [NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g]   = 1'b0;
         grp_first_in[g] = '0;
         grp_tag_in[g]   = '0;
         grp_qty_in[g]   = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            grp_tag_in[g] = grp_tag_in[g] | hits[g*GROUP_SIZE + j].rd_tag;
            grp_qty_in[g] = grp_qty_in[g] | hits[g*GROUP_SIZE + j].rd_qty;
            if (hits[g*GROUP_SIZE + j].find_hit && !grp_any_in[g]) begin
               grp_any_in[g]   = 1'b1;
               grp_first_in[g] = GRP_BITS'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any_ff[g]   <= grp_any_in[g];
            grp_first_ff[g] <= grp_first_in[g];
            grp_tag_ff[g]   <= grp_tag_in[g];
            grp_qty_ff[g]   <= grp_qty_in[g];
         end
      end
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         result.tag = result.tag | grp_tag_ff[g];
         result.qty = result.qty | grp_qty_ff[g];
         if (grp_any_ff[g] && !result.found) begin
            result.found = 1'b1;
            result.index = {GIDX_BITS'(g), grp_first_ff[g]};
         end
      end
   end

endmodule

>>> hw/rtl/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// Positional list store core
// Bounded ordered list of (tag, quantity) entries held in a row of cells.
//
// Requests arrive on req_port and results leave on rsp_port, both valid/ready
// channels; a transfer happens when valid and ready are high at a clock edge.
// Each request is insert, remove, read, write or find and gives exactly one
// result with status, read entry, found index and the new entry count.
// One request is worked at a time. After a request is taken, the cells shift
// or update, then the group level of the match tree is loaded, and then the
// result enters the output register once that register is free. A new request
// is taken only after the result of the last one has entered the output
// register, so the walk through those three steps sets the request rate.
// The output register holds a finished result while the receiver stalls, and
// the next request is still taken meanwhile; the block waits only when a
// second result is ready and the first has not been taken.
// Reset is synchronous and empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_store_core import pls_pkg::*; (
   input logic     clock,
   input logic     reset,
   pls_req_if.sink   req_port,
   pls_rsp_if.source rsp_port
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RED1 = 2'd2;
   localparam logic [1:0] S_RED2 = 2'd3;

   typedef struct packed {
      logic [1:0]             op;
      logic [IDX_BITS-1:0]    pos;
      logic [TAG_BITS-1:0]    tag;
      logic [QTY_BITS-1:0]    qty;
      logic                   read_en;
      logic                   find_en;
      logic [CNT_BITS-1:0]    count_old;
      logic [CNT_BITS-1:0]    count_new;
      logic [STATUS_BITS-1:0] status;
   } pend_type;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   pend_type               pend_ff;
   pend_type               pend_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff;
   logic [TAG_BITS-1:0]    item_ff;
   logic [QTY_BITS-1:0]    qty_ff;
   logic [IDX_BITS-1:0]    index_ff;
   logic [CNT_BITS-1:0]    entry_count_ff;

   logic                   req_take;
   logic                   rsp_load;
   logic                   pos_neg;
   logic [CNT_BITS-1:0]    pos_mag;
   logic                   in_range;
   cell_cmd_type           cmd;
   entry_type              entries [MAX_ENTRIES];
   cell_hit_type           hits    [MAX_ENTRIES];
   reduce_result_type      red;

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign rsp_load       = (state_ff == S_RED2) && (!rsp_valid_ff || rsp_port.ready);

   assign pos_neg  = req_port.position[POS_BITS-1];
   assign pos_mag  = CNT_BITS'(req_port.position[POS_BITS-2:0]);
   assign in_range = !pos_neg && (pos_mag < count_ff);

   always_comb begin
      pend_in           = '0;
      pend_in.op        = CELL_HOLD;
      pend_in.tag       = req_port.item_tag;
      pend_in.qty       = req_port.quantity;
      pend_in.count_old = count_ff;
      pend_in.status    = ST_OK;
      count_in          = count_ff;
      case (req_port.req_type)
         REQ_INSERT: begin
            if (count_ff == CNT_BITS'(MAX_ENTRIES)) begin
               pend_in.status = ST_FULL;
            end else begin
               pend_in.op = CELL_INSERT;
               if (pos_neg) begin
                  pend_in.pos = '0;
               end else if (pos_mag > count_ff) begin
                  pend_in.pos = count_ff[IDX_BITS-1:0];
               end else begin
                  pend_in.pos = pos_mag[IDX_BITS-1:0];
               end
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         REQ_REMOVE: begin
            if (count_ff == '0) begin
               pend_in.status = ST_RANGE;
            end else begin
               pend_in.op = CELL_REMOVE;
               if (pos_neg) begin
                  pend_in.pos = '0;
               end else if (pos_mag >= count_ff) begin
                  pend_in.pos = IDX_BITS'(count_ff - CNT_BITS'(1));
               end else begin
                  pend_in.pos = pos_mag[IDX_BITS-1:0];
               end
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         REQ_READ: begin
            if (in_range) begin
               pend_in.read_en = 1'b1;
               pend_in.pos     = pos_mag[IDX_BITS-1:0];
            end else begin
               pend_in.status = ST_RANGE;
            end
         end
         REQ_WRITE: begin
            if (in_range) begin
               pend_in.op  = CELL_WRITE;
               pend_in.pos = pos_mag[IDX_BITS-1:0];
            end else begin
               pend_in.status = ST_RANGE;
            end
         end
         REQ_FIND: begin
            pend_in.find_en = 1'b1;
         end
         default: begin
            pend_in.status = ST_OK;
         end
      endcase
      pend_in.count_new = count_in;
   end

   always_comb begin
      cmd.exec    = (state_ff == S_EXEC);
      cmd.op      = cmd.exec ? pend_ff.op : CELL_HOLD;
      cmd.pos     = pend_ff.pos;
      cmd.tag     = pend_ff.tag;
      cmd.qty     = pend_ff.qty;
      cmd.read_en = pend_ff.read_en;
      cmd.find_en = pend_ff.find_en;
      cmd.count   = pend_ff.count_old;
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      if (i == 0) begin : g_first
         assign left_entry = entries[i];
      end else begin : g_inner_left
         assign left_entry = entries[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_inner_right
         assign right_entry = entries[i+1];
      end
      pls_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (IDX_BITS'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .hit         (hits[i])
      );
   end

   pls_reduce u_reduce (
      .clock  (clock),
      .load   (state_ff == S_RED1),
      .hits   (hits),
      .result (red)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RED1;
         end
         S_RED1: begin
            state_in = S_RED2;
         end
         S_RED2: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (req_take) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pend_ff <= pend_in;
      end
      if (rsp_load) begin
         if (pend_ff.find_en) begin
            status_ff <= red.found ? ST_OK : ST_MISS;
         end else begin
            status_ff <= pend_ff.status;
         end
         item_ff        <= red.tag;
         qty_ff         <= red.qty;
         index_ff       <= red.found ? red.index : '0;
         entry_count_ff <= pend_ff.count_new;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = status_ff;
   assign rsp_port.item_out     = item_ff;
   assign rsp_port.quantity_out = qty_ff;
   assign rsp_port.found_index  = index_ff;
   assign rsp_port.entry_count  = entry_count_ff;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list store testbench
// Sends insert, remove, read, write and find requests, and a few unused
// request codes, to the list core. A shadow copy of the list predicts every
// result when its request is taken, and each result is compared field by
// field in arrival order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import pls_pkg::*;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SPARE_LAST  = 3'd7;
   localparam int MAX_IDLE     = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [TAG_BITS-1:0]    item;
      logic [QTY_BITS-1:0]    qty;
      logic [IDX_BITS-1:0]    index;
      logic [CNT_BITS-1:0]    count;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   bit   steady_flow = 1'b0;

   logic [TAG_BITS-1:0] shadow_tags [MAX_ENTRIES];
   logic [QTY_BITS-1:0] shadow_qtys [MAX_ENTRIES];
   int                  shadow_count = 0;
   list_result_type     pending_results [$];

   pls_req_if req_if ();
   pls_rsp_if rsp_if ();

   positional_list_store_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int idle_cycles();
      if (steady_flow || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, MAX_IDLE);
   endfunction

   // Applies one request to the shadow list and returns the result it gives.
   function automatic list_result_type list_apply(input logic [REQ_TYPE_BITS-1:0] kind,
                                                  input logic signed [POS_BITS-1:0] position,
                                                  input logic [TAG_BITS-1:0] tag,
                                                  input logic [QTY_BITS-1:0] qty);
      list_result_type res;
      int slot;
      res = '0;
      res.status = ST_OK;
      slot = position;
      case (kind)
         REQ_INSERT: begin
            if (shadow_count >= MAX_ENTRIES) begin
               res.status = ST_FULL;
            end else begin
               if (slot < 0) slot = 0;
               if (slot > shadow_count) slot = shadow_count;
               for (int i = shadow_count; i > slot; i--) begin
                  shadow_tags[i] = shadow_tags[i-1];
                  shadow_qtys[i] = shadow_qtys[i-1];
               end
               shadow_tags[slot] = tag;
               shadow_qtys[slot] = qty;
               shadow_count++;
            end
         end
         REQ_REMOVE: begin
            if (shadow_count <= 0) begin
               res.status = ST_RANGE;
            end else begin
               if (slot < 0) slot = 0;
               if (slot > shadow_count - 1) slot = shadow_count - 1;
               for (int i = slot; i < shadow_count - 1; i++) begin
                  shadow_tags[i] = shadow_tags[i+1];
                  shadow_qtys[i] = shadow_qtys[i+1];
               end
               shadow_count--;
            end
         end
         REQ_READ: begin
            if (slot < 0 || slot >= shadow_count) begin
               res.status = ST_RANGE;
            end else begin
               res.item = shadow_tags[slot];
               res.qty  = shadow_qtys[slot];
            end
         end
         REQ_WRITE: begin
            if (slot < 0 || slot >= shadow_count) begin
               res.status = ST_RANGE;
            end else begin
               shadow_tags[slot] = tag;
               shadow_qtys[slot] = qty;
            end
         end
         REQ_FIND: begin
            // Scanning downward leaves the lowest matching index in place.
            res.status = ST_MISS;
            for (int i = shadow_count - 1; i >= 0; i--) begin
               if (shadow_tags[i] == tag) begin
                  res.status = ST_OK;
                  res.index  = IDX_BITS'(i);
               end
            end
         end
         default: begin
         end
      endcase
      res.count = CNT_BITS'(shadow_count);
      return res;
   endfunction

   function automatic logic signed [POS_BITS-1:0] rand_position();
      case ($urandom_range(0, 9))
         0: return POS_BITS'($urandom());
         1: return POS_BITS'(shadow_count);
         default: return (shadow_count == 0) ? '0 :
                         POS_BITS'($urandom_range(0, shadow_count - 1));
      endcase
   endfunction

   function automatic logic [TAG_BITS-1:0] rand_tag();
      // A small pool of tags makes duplicates common, so the first match matters.
      if ($urandom_range(0, 3) == 0) begin
         return TAG_BITS'($urandom_range(0, 7));
      end
      return TAG_BITS'($urandom());
   endfunction

   function automatic logic [QTY_BITS-1:0] rand_quantity();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic [REQ_TYPE_BITS-1:0] kind,
                               input logic signed [POS_BITS-1:0] position,
                               input logic [TAG_BITS-1:0] tag,
                               input logic [QTY_BITS-1:0] qty);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.req_type <= kind;
      req_if.position <= position;
      req_if.item_tag <= tag;
      req_if.quantity <= qty;
      req_if.valid    <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_results.push_back(list_apply(kind, position, tag, qty));
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_boundary_requests();
      send_request(REQ_REMOVE, 0, 16'h0000, 32'h0);
      send_request(REQ_READ, 0, 16'h0000, 32'h0);
      send_request(REQ_WRITE, 0, 16'h1111, 32'h1);
      send_request(REQ_FIND, 0, 16'h0000, 32'h0);
      send_request(REQ_SPARE_FIRST, -1, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(REQ_SPARE_LAST, 127, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, -128, 16'hFFFF, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 127, 16'h0000, 32'h8000_0000);
      send_request(REQ_INSERT, 1, 16'h5A5A, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 0, 16'h5A5A, 32'h0);
      send_request(REQ_FIND, 0, 16'h5A5A, 32'h0);
      send_request(REQ_FIND, 0, 16'h1234, 32'h0);
      send_request(REQ_READ, -1, 16'h0000, 32'h0);
      send_request(REQ_READ, 4, 16'h0000, 32'h0);
      send_request(REQ_READ, 127, 16'h0000, 32'h0);
      send_request(REQ_READ, 3, 16'h0000, 32'h0);
      send_request(REQ_READ, 0, 16'h0000, 32'h0);
      send_request(REQ_WRITE, 2, 16'hA5A5, 32'h1234_5678);
      send_request(REQ_WRITE, 4, 16'hBEEF, 32'h1);
      send_request(REQ_WRITE, -1, 16'hBEEF, 32'h1);
      send_request(REQ_READ, 2, 16'h0000, 32'h0);
      send_request(REQ_REMOVE, -5, 16'h0000, 32'h0);
      send_request(REQ_REMOVE, 127, 16'h0000, 32'h0);
      send_request(REQ_REMOVE, 1, 16'h0000, 32'h0);
      send_request(REQ_REMOVE, 0, 16'h0000, 32'h0);
      send_request(REQ_REMOVE, 0, 16'h0000, 32'h0);
   endtask

   task automatic test_fill_and_drain();
      while (shadow_count < MAX_ENTRIES) begin
         send_request(REQ_INSERT, rand_position(), rand_tag(), rand_quantity());
      end
      send_request(REQ_INSERT, 0, rand_tag(), rand_quantity());
      send_request(REQ_INSERT, 127, rand_tag(), rand_quantity());
      send_request(REQ_READ, MAX_ENTRIES - 1, 16'h0000, 32'h0);
      send_request(REQ_FIND, 0, shadow_tags[MAX_ENTRIES-1], 32'h0);
      send_request(REQ_WRITE, MAX_ENTRIES - 1, rand_tag(), rand_quantity());
      send_request(REQ_READ, MAX_ENTRIES, 16'h0000, 32'h0);
      while (shadow_count > 0) begin
         send_request(REQ_REMOVE, rand_position(), 16'h0000, 32'h0);
      end
      send_request(REQ_REMOVE, -1, 16'h0000, 32'h0);
   endtask

   task automatic send_random_request(input int bias);
      int roll;
      int grow;
      logic [REQ_TYPE_BITS-1:0] kind;
      logic [TAG_BITS-1:0] tag;
      roll = $urandom_range(0, 99);
      grow = (bias == 0) ? 40 : (bias == 1) ? 10 : 25;
      if (roll < 2) begin
         kind = REQ_TYPE_BITS'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      end else if (roll < 2 + grow) begin
         kind = REQ_INSERT;
      end else if (roll < 52) begin
         kind = REQ_REMOVE;
      end else if (roll < 70) begin
         kind = REQ_READ;
      end else if (roll < 85) begin
         kind = REQ_WRITE;
      end else begin
         kind = REQ_FIND;
      end
      if (kind == REQ_FIND && shadow_count > 0 && $urandom_range(0, 3) != 0) begin
         tag = shadow_tags[$urandom_range(0, shadow_count - 1)];
      end else begin
         tag = rand_tag();
      end
      send_request(kind, rand_position(), tag, rand_quantity());
   endtask

   task automatic test_pause_until_drained();
      steady_flow = 1'b1;
      repeat (8) send_random_request(0);
      hold_until_drained();
      steady_flow = 1'b0;
      repeat (8) send_random_request(2);
      hold_until_drained();
   endtask

   task automatic test_random_traffic(input int total);
      int bias;
      bias = 2;
      for (int n = 0; n < total; n++) begin
         if (n % 100 == 0) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            bias = $urandom_range(0, 2);
         end
         if (n % 250 == 249) begin
            hold_until_drained();
         end
         send_random_request(bias);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected result at cycle %0d: status %0d count %0d",
                        cycle_count, rsp_if.status, rsp_if.entry_count);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.item_out !== want.item ||
                rsp_if.quantity_out !== want.qty || rsp_if.found_index !== want.index ||
                rsp_if.entry_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch at cycle %0d: expected st %0d tag %h qty %0d idx %0d cnt %0d",
                           cycle_count, want.status, want.item, $signed(want.qty),
                           want.index, want.count);
                  $display("                         actual st %0d tag %h qty %0d idx %0d cnt %0d",
                           rsp_if.status, rsp_if.item_out, rsp_if.quantity_out,
                           rsp_if.found_index, rsp_if.entry_count);
               end
            end
         end
      end
   end

   initial begin
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_INSERT;
      req_if.position = '0;
      req_if.item_tag = '0;
      req_if.quantity = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_boundary_requests();
      test_fill_and_drain();
      test_pause_until_drained();
      test_random_traffic(1070);

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pls_pkg.sv
hw/rtl/pls_req_if.sv
hw/rtl/pls_rsp_if.sv
hw/rtl/pls_cell.sv
hw/rtl/pls_reduce.sv
hw/rtl/positional_list_store_core.sv
sim/tb_top.sv
